FILE: design/q2rm_pkg.sv
`default_nettype none
package q2rm_pkg;

  localparam int CompWidth = 16;
  localparam int FracBits = 14;
  localparam int ProdWidth = 2 * CompWidth;
  localparam int NormWidth = ProdWidth + 2;
  localparam int NumWidth = ProdWidth + 2;
  localparam int MagWidth = NumWidth - 1;
  localparam int RemWidth = NormWidth + 1;
  localparam int Entries = 9;
  localparam int DivSteps = FracBits + 1;

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic [NormWidth-1:0] norm_t;
  typedef logic signed [NumWidth-1:0] num_t;
  typedef logic [RemWidth-1:0] rem_t;
  typedef logic [FracBits:0] quo_t;

  typedef struct packed {
    comp_t comp_w;
    comp_t comp_x;
    comp_t comp_y;
    comp_t comp_z;
  } quat_t;

  typedef struct packed {
    comp_t row0_col0;
    comp_t row0_col1;
    comp_t row0_col2;
    comp_t row1_col0;
    comp_t row1_col1;
    comp_t row1_col2;
    comp_t row2_col0;
    comp_t row2_col1;
    comp_t row2_col2;
    logic  zero_norm;
  } matrix_t;

  typedef struct packed {
    rem_t [Entries-1:0] rem;
    quo_t [Entries-1:0] quo;
    logic [Entries-1:0] neg;
    logic [Entries-1:0] sat;
    norm_t              den;
    logic               zero;
  } div_state_t;

endpackage
`default_nettype wire

FILE: design/quaternion_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix.
// Input channel in_valid/in_ready carries one quaternion (w, x, y, z), Q2.14,
// per transfer; output channel out_valid/out_ready carries the nine matrix
// entries row-major in Q2.14, each divided by the squared norm, plus zero_norm.
// A zero quaternion gives the identity matrix with zero_norm set.
// Throughput: one quaternion per clock while the output is not stalled. The
// multiply register loads at the input transfer itself,
// followed by one sum/setup stage, fifteen restoring division stages (fourteen
// quotient bits and one rounding bit, all nine entries in parallel) and one
// rounding/output register.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; while the receiver stalls, in_ready falls and every stage holds.
// Synchronous reset rst clears all valid bits; no result is pending after it.
`default_nettype none
module quaternion_to_rotation_matrix_top
  import q2rm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire quat_t   in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output matrix_t      out_data
);

  logic                advance;
  logic                p_valid;
  num_t [Entries-1:0]  p_num;
  norm_t               p_norm;

  logic                s_valid;
  div_state_t          s_state;
  div_state_t          setup;

  logic       [DivSteps:0] v_chain;
  div_state_t [DivSteps:0] d_chain;

  logic [MagWidth-1:0] mag;
  matrix_t             res;
  comp_t [Entries-1:0] ent;

  assign advance = !out_valid || out_ready;
  assign in_ready = advance;

  q2rm_products u_products (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .quat      (in_data),
    .out_valid (p_valid),
    .num       (p_num),
    .norm      (p_norm)
  );

  always_comb begin
    setup = '0;
    setup.den = p_norm;
    setup.zero = (p_norm == '0);
    mag = '0;
    for (int k = 0; k < Entries; k++) begin
      setup.neg[k] = p_num[k][NumWidth-1];
      mag = p_num[k][NumWidth-1] ? MagWidth'(-p_num[k]) : MagWidth'(p_num[k]);
      setup.sat[k] = (NormWidth'(mag) >= p_norm);
      setup.rem[k] = setup.sat[k] ? '0 : rem_t'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (advance) begin
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s_state <= setup;
    end
  end

  assign v_chain[0] = s_valid;
  assign d_chain[0] = s_state;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    q2rm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (v_chain[g]),
      .din       (d_chain[g]),
      .out_valid (v_chain[g+1]),
      .dout      (d_chain[g+1])
    );
  end

  always_comb begin
    div_state_t f;
    quo_t       q;
    logic [FracBits+1:0] r;
    f = d_chain[DivSteps];
    q = '0;
    r = '0;
    for (int k = 0; k < Entries; k++) begin
      q = f.quo[k] >> 1;
      r = {1'b0, q} + {{(FracBits+1){1'b0}}, f.quo[k][0]};
      if (f.sat[k] || r > (FracBits+2)'(1 << FracBits)) begin
        r = (FracBits+2)'(1 << FracBits);
      end
      ent[k] = f.neg[k] ? -comp_t'(r) : comp_t'(r);
      if (f.zero) begin
        ent[k] = (k == 0 || k == 4 || k == 8) ? comp_t'(1 << FracBits) : '0;
      end
    end
    res.row0_col0 = ent[0];
    res.row0_col1 = ent[1];
    res.row0_col2 = ent[2];
    res.row1_col0 = ent[3];
    res.row1_col1 = ent[4];
    res.row1_col2 = ent[5];
    res.row2_col0 = ent[6];
    res.row2_col1 = ent[7];
    res.row2_col2 = ent[8];
    res.zero_norm = f.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v_chain[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_norm |->
      out_data.row0_col0 == comp_t'(1 << FracBits) && out_data.row0_col1 == '0)
    else $error("zero quaternion did not give identity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(v_chain))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

FILE: design/q2rm_products.sv
`default_nettype none
module q2rm_products
  import q2rm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        in_valid,
  input  wire quat_t       quat,
  output logic             out_valid,
  output num_t  [Entries-1:0] num,
  output norm_t            norm
);

  prod_t sw, sx, sy, sz, xy, zw, xz, yw, yz, xw;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sw <= quat.comp_w * quat.comp_w;
      sx <= quat.comp_x * quat.comp_x;
      sy <= quat.comp_y * quat.comp_y;
      sz <= quat.comp_z * quat.comp_z;
      xy <= quat.comp_x * quat.comp_y;
      zw <= quat.comp_z * quat.comp_w;
      xz <= quat.comp_x * quat.comp_z;
      yw <= quat.comp_y * quat.comp_w;
      yz <= quat.comp_y * quat.comp_z;
      xw <= quat.comp_x * quat.comp_w;
    end
  end

  always_comb begin
    num[0] = num_t'(sw) + num_t'(sx) - num_t'(sy) - num_t'(sz);
    num[1] = (num_t'(xy) - num_t'(zw)) <<< 1;
    num[2] = (num_t'(xz) + num_t'(yw)) <<< 1;
    num[3] = (num_t'(xy) + num_t'(zw)) <<< 1;
    num[4] = num_t'(sw) - num_t'(sx) + num_t'(sy) - num_t'(sz);
    num[5] = (num_t'(yz) - num_t'(xw)) <<< 1;
    num[6] = (num_t'(xz) - num_t'(yw)) <<< 1;
    num[7] = (num_t'(yz) + num_t'(xw)) <<< 1;
    num[8] = num_t'(sw) - num_t'(sx) - num_t'(sy) + num_t'(sz);
    norm = norm_t'(unsigned'(sw)) + norm_t'(unsigned'(sx))
         + norm_t'(unsigned'(sy)) + norm_t'(unsigned'(sz));
  end

endmodule
`default_nettype wire

FILE: design/q2rm_div_step.sv
`default_nettype none
module q2rm_div_step
  import q2rm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic       in_valid,
  input  wire div_state_t din,
  output logic            out_valid,
  output div_state_t      dout
);

  div_state_t nxt;
  rem_t       sh;

  always_comb begin
    nxt = din;
    sh = '0;
    for (int k = 0; k < Entries; k++) begin
      sh = din.rem[k] << 1;
      if (sh >= rem_t'(din.den)) begin
        nxt.rem[k] = sh - rem_t'(din.den);
        nxt.quo[k] = {din.quo[k][FracBits-1:0], 1'b1};
      end else begin
        nxt.rem[k] = sh;
        nxt.quo[k] = {din.quo[k][FracBits-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
  import q2rm_pkg::*;

  localparam int Latency = 18;
  localparam int CycleLimit = 200000;
  localparam int RandomItems = 400;
  localparam logic signed [15:0] One = 16'sd16384;

  typedef struct {
    quat_t q;
    logic check_fixed;
    matrix_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  quat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  matrix_t out_data;

  matrix_t expected_matrices[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int received = 0;
  int zero_seen = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  quaternion_to_rotation_matrix_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] scaled_quotient(longint num, longint den);
    longint mag;
    longint rem;
    longint q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag >= den) begin
      q = 1 << FracBits;
    end else begin
      rem = mag;
      q = 0;
      for (int i = 0; i < FracBits; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q | 1;
        end
      end
      if ((rem << 1) >= den) q = q + 1;
      if (q > (1 << FracBits)) q = 1 << FracBits;
    end
    if (neg) q = -q;
    return q[15:0];
  endfunction

  function automatic matrix_t rotation_of(quat_t q);
    longint w, x, y, z, sw, sx, sy, sz, nrm;
    matrix_t m;
    w = q.comp_w;
    x = q.comp_x;
    y = q.comp_y;
    z = q.comp_z;
    sw = w * w;
    sx = x * x;
    sy = y * y;
    sz = z * z;
    nrm = sw + sx + sy + sz;
    m = '0;
    if (nrm == 0) begin
      m.row0_col0 = One;
      m.row1_col1 = One;
      m.row2_col2 = One;
      m.zero_norm = 1'b1;
      return m;
    end
    m.row0_col0 = scaled_quotient(sw + sx - sy - sz, nrm);
    m.row0_col1 = scaled_quotient(2 * (x * y - z * w), nrm);
    m.row0_col2 = scaled_quotient(2 * (x * z + y * w), nrm);
    m.row1_col0 = scaled_quotient(2 * (x * y + z * w), nrm);
    m.row1_col1 = scaled_quotient(sw - sx + sy - sz, nrm);
    m.row1_col2 = scaled_quotient(2 * (y * z - x * w), nrm);
    m.row2_col0 = scaled_quotient(2 * (x * z - y * w), nrm);
    m.row2_col1 = scaled_quotient(2 * (y * z + x * w), nrm);
    m.row2_col2 = scaled_quotient(sw - sx - sy + sz, nrm);
    m.zero_norm = 1'b0;
    return m;
  endfunction

  function automatic quat_t quat(int w, int x, int y, int z);
    quat_t q;
    q.comp_w = w[15:0];
    q.comp_x = x[15:0];
    q.comp_y = y[15:0];
    q.comp_z = z[15:0];
    return q;
  endfunction

  function automatic matrix_t diag(int a, int b, int c);
    matrix_t m;
    m = '0;
    m.row0_col0 = a[15:0];
    m.row1_col1 = b[15:0];
    m.row2_col2 = c[15:0];
    return m;
  endfunction

  function automatic comp_t random_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1: return comp_t'($urandom_range(0, 8) - 4);
      2: return comp_t'($urandom_range(0, 32768) - 16384);
      default: return comp_t'($urandom());
    endcase
  endfunction

  // called at a falling edge; leaves at the falling edge after the transfer
  task automatic send(quat_t q, matrix_t exp_m);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_matrices.push_back(exp_m);
    sent++;
    @(negedge clk);
  endtask

  row_t table_rows[$];
  row_t r;

  initial begin
    table_rows.push_back('{quat(0, 0, 0, 0), 1'b1, diag(16384, 16384, 16384) | 1'b1});
    table_rows.push_back('{quat(16384, 0, 0, 0), 1'b1, diag(16384, 16384, 16384)});
    table_rows.push_back('{quat(-32768, 0, 0, 0), 1'b1, diag(16384, 16384, 16384)});
    table_rows.push_back('{quat(32767, 0, 0, 0), 1'b1, diag(16384, 16384, 16384)});
    table_rows.push_back('{quat(0, 16384, 0, 0), 1'b1, diag(16384, -16384, -16384)});
    table_rows.push_back('{quat(0, 0, -32768, 0), 1'b1, diag(-16384, 16384, -16384)});
    table_rows.push_back('{quat(0, 0, 0, 1), 1'b1, diag(-16384, -16384, 16384)});
    table_rows.push_back('{quat(1, 0, 0, 0), 1'b1, diag(16384, 16384, 16384)});
    table_rows.push_back('{quat(32767, 32767, 32767, 32767), 1'b0, '0});
    table_rows.push_back('{quat(-32768, -32768, -32768, -32768), 1'b0, '0});
    table_rows.push_back('{quat(-32768, 32767, -32768, 32767), 1'b0, '0});
    table_rows.push_back('{quat(11585, 11585, 0, 0), 1'b0, '0});
    table_rows.push_back('{quat(1, 1, 1, 1), 1'b0, '0});
    table_rows.push_back('{quat(1, -1, 0, 0), 1'b0, '0});
    table_rows.push_back('{quat(0, 3, 4, 0), 1'b0, '0});
    table_rows.push_back('{quat(-1, 0, 0, 0), 1'b0, '0});
    table_rows.push_back('{quat(16384, 1, -1, 2), 1'b0, '0});
    table_rows.push_back('{quat(-21845, 10922, 5461, -43), 1'b0, '0});
    table_rows.push_back('{quat(0, -32768, 32767, 0), 1'b0, '0});
    table_rows.push_back('{quat(21846, 0, 0, -21846), 1'b0, '0});
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) begin
      r = table_rows[i];
      send(r.q, r.check_fixed ? r.fixed : rotation_of(r.q));
    end
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 29) == 0) r.q = quat(0, 0, 0, 0);
      else r.q = '{random_comp(), random_comp(), random_comp(), random_comp()};
      send(r.q, rotation_of(r.q));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // hold the receiver off for a long stretch while the sender keeps offering items
  initial begin
    wait (!rst);
    wait (sent > 60);
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= !hold_off;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      matrix_t e;
      received++;
      if (expected_matrices.size() == 0) begin
        $error("unexpected transfer: %p", out_data);
        errors++;
      end else begin
        e = expected_matrices.pop_front();
        if (e.zero_norm) zero_seen++;
        if (out_data.row0_col0 !== e.row0_col0) begin
          $error("row0_col0 exp %0d got %0d", e.row0_col0, out_data.row0_col0); errors++;
        end
        if (out_data.row0_col1 !== e.row0_col1) begin
          $error("row0_col1 exp %0d got %0d", e.row0_col1, out_data.row0_col1); errors++;
        end
        if (out_data.row0_col2 !== e.row0_col2) begin
          $error("row0_col2 exp %0d got %0d", e.row0_col2, out_data.row0_col2); errors++;
        end
        if (out_data.row1_col0 !== e.row1_col0) begin
          $error("row1_col0 exp %0d got %0d", e.row1_col0, out_data.row1_col0); errors++;
        end
        if (out_data.row1_col1 !== e.row1_col1) begin
          $error("row1_col1 exp %0d got %0d", e.row1_col1, out_data.row1_col1); errors++;
        end
        if (out_data.row1_col2 !== e.row1_col2) begin
          $error("row1_col2 exp %0d got %0d", e.row1_col2, out_data.row1_col2); errors++;
        end
        if (out_data.row2_col0 !== e.row2_col0) begin
          $error("row2_col0 exp %0d got %0d", e.row2_col0, out_data.row2_col0); errors++;
        end
        if (out_data.row2_col1 !== e.row2_col1) begin
          $error("row2_col1 exp %0d got %0d", e.row2_col1, out_data.row2_col1); errors++;
        end
        if (out_data.row2_col2 !== e.row2_col2) begin
          $error("row2_col2 exp %0d got %0d", e.row2_col2, out_data.row2_col2); errors++;
        end
        if (out_data.zero_norm !== e.zero_norm) begin
          $error("zero_norm exp %0b got %0b", e.zero_norm, out_data.zero_norm); errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_matrices.size() == 0);
    repeat (Latency + 4) @(posedge clk);
    errors += expected_matrices.size();
    $display("Sent %0d quaternions, checked %0d matrices, %0d of them zero-norm.",
             sent, received, zero_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: quaternion_to_rotation_matrix_top.f
design/q2rm_pkg.sv
design/q2rm_products.sv
design/q2rm_div_step.sv
design/quaternion_to_rotation_matrix_top.sv
dv/tb.sv
